// ===== design/jkf_pkg.sv =====
`default_nettype none

package jkf_pkg;

    // Field widths fixed by the interface
    localparam int BYTE_W       = 8;
    localparam int KEY_W        = 64;
    localparam int KEY_LEN_W    = 4;
    localparam int KEY_OFFSET_W = 32;
    localparam int CFG_INDEX_W  = 2;

    typedef logic [BYTE_W-1:0]      byte_t;
    typedef logic [KEY_LEN_W-1:0]   key_len_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    // Configuration register indexes
    localparam cfg_index_t CFG_KEY_BYTES  = 2'd0;
    localparam cfg_index_t CFG_KEY_LENGTH = 2'd1;

    // Characters of interest
    localparam byte_t CH_LBRACE    = 8'h7B;
    localparam byte_t CH_RBRACE    = 8'h7D;
    localparam byte_t CH_LBRACKET  = 8'h5B;
    localparam byte_t CH_RBRACKET  = 8'h5D;
    localparam byte_t CH_COLON     = 8'h3A;
    localparam byte_t CH_COMMA     = 8'h2C;
    localparam byte_t CH_QUOTE     = 8'h22;
    localparam byte_t CH_BACKSLASH = 8'h5C;
    localparam byte_t CH_SPACE     = 8'h20;
    localparam byte_t CH_TAB       = 8'h09;
    localparam byte_t CH_LF        = 8'h0A;
    localparam byte_t CH_CR        = 8'h0D;

    // Whitespace between tokens
    function automatic logic is_blank(input byte_t b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
    endfunction

    // Bytes that end a scalar value
    function automatic logic is_stop(input byte_t b);
        return (b == CH_COMMA) || (b == CH_RBRACE) || (b == CH_RBRACKET)
            || (b == CH_COLON);
    endfunction

endpackage

`default_nettype wire

// ===== design/json_key_finder_top.sv =====
`default_nettype none

// JSON key finder. Streams a JSON document in one byte per word on the slave
// side and searches it for the key held in the configuration registers (key
// characters in cfg index 0, first character lowest; key length in index 1).
// Each quoted string is compared raw against the key; a string of the key's
// length with equal bytes, followed by a colon after optional blanks, is a
// match, and one result word gives found=1 with the offset of its opening
// quote. Values of other keys are skipped. If the document ends (tlast) with
// no match, one result word with found=0 and offset 0 comes out at the last
// byte. The block then rearms for the next document. One byte is taken every
// clock: each byte passes through an input register, the combinational scan
// logic and an output register, which holds the result word; the only stall
// is back pressure on the master side.
// Write the configuration only while no document is in flight.
module json_key_finder_top #(
    parameter int KEY_BYTES   = 8,
    parameter int OFFSET_BITS = 32,
    parameter int DEPTH_BITS  = 16
) (
    input  wire                         clk,
    input  wire                         rst_n,
    // Document bytes
    input  wire                         s_tvalid,
    output logic                        s_tready,
    input  wire  [7:0]                  s_tdata,   // [7:0] data_byte
    input  wire                         s_tlast,   // last_byte
    // Search results
    output logic                        m_tvalid,
    input  wire                         m_tready,
    output logic [31:0]                 m_tdata,   // [31:0] key_offset
    output logic                        m_tuser,   // found
    // Configuration writes
    input  wire                         cfg_valid,
    output logic                        cfg_ready,
    input  wire  jkf_pkg::cfg_index_t   cfg_index,
    input  wire  [jkf_pkg::KEY_W-1:0]   cfg_data
);
    import jkf_pkg::*;

    typedef enum logic [3:0] {
        M_SEARCH,
        M_KEY,
        M_KEY_ESC,
        M_AFTER_KEY,
        M_PRE_VALUE,
        M_VSTR,
        M_VSTR_ESC,
        M_OBJ,
        M_OBJ_STR,
        M_OBJ_ESC,
        M_ARR,
        M_ARR_STR,
        M_ARR_ESC,
        M_SCALAR
    } mode_t;

    typedef logic [OFFSET_BITS-1:0] offset_t;
    typedef logic [DEPTH_BITS-1:0]  depth_t;

    // Configuration
    logic [KEY_W-1:0] key_bytes_reg;
    key_len_t         key_length_reg;

    // Input stage
    logic  in_valid_reg;
    byte_t in_byte_reg;
    logic  in_last_reg;

    // Scan state
    mode_t    mode_reg,         mode_next;
    offset_t  byte_count_reg,   byte_count_next;
    offset_t  quote_offset_reg, quote_offset_next;
    key_len_t match_index_reg,  match_index_next;
    logic     match_good_reg,   match_good_next;
    depth_t   skip_depth_reg,   skip_depth_next;
    logic     reported_reg,     reported_next;

    // Output stage
    logic                    out_valid_reg;
    logic                    out_found_reg;
    logic [KEY_OFFSET_W-1:0] out_offset_reg;

    logic  proceed;
    logic  match;
    logic  out_load;
    logic  feed_good;
    logic  key_full;
    byte_t key_sel;
    byte_t b;

    assign cfg_ready = 1'b1;
    assign proceed   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proceed;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_found_reg;
    assign m_tdata   = out_offset_reg;

    // Compare the current byte against the next expected key character
    assign b         = in_byte_reg;
    assign key_sel   = byte_t'(key_bytes_reg >> {match_index_reg[2:0], 3'b000});
    assign feed_good = (match_index_reg < key_length_reg)
                    && (match_index_reg < KEY_LEN_W'(KEY_BYTES))
                    && (key_sel == b);
    assign key_full  = (match_index_reg == '1);

    // Scan one byte
    always_comb
    begin
        mode_next         = mode_reg;
        byte_count_next   = byte_count_reg;
        quote_offset_next = quote_offset_reg;
        match_index_next  = match_index_reg;
        match_good_next   = match_good_reg;
        skip_depth_next   = skip_depth_reg;
        reported_next     = reported_reg;
        match             = 1'b0;

        if (proceed && !reported_reg)
        begin
            unique case (mode_reg)
                M_SEARCH, M_AFTER_KEY:
                begin
                    if (mode_reg == M_AFTER_KEY && is_blank(b))
                    begin
                        mode_next = M_AFTER_KEY;
                    end
                    else if (mode_reg == M_AFTER_KEY && b == CH_COLON)
                    begin
                        if (match_good_reg)
                            match = 1'b1;
                        else
                            mode_next = M_PRE_VALUE;
                    end
                    else if (b == CH_QUOTE)
                    begin
                        quote_offset_next = byte_count_reg;
                        match_index_next  = '0;
                        match_good_next   = 1'b1;
                        mode_next         = M_KEY;
                    end
                    else
                    begin
                        mode_next = M_SEARCH;
                    end
                end
                M_KEY, M_KEY_ESC:
                begin
                    if (mode_reg == M_KEY && b == CH_QUOTE)
                    begin
                        match_good_next = match_good_reg
                                       && (match_index_reg == key_length_reg);
                        mode_next = M_AFTER_KEY;
                    end
                    else
                    begin
                        match_good_next = match_good_reg && feed_good;
                        if (!key_full)
                            match_index_next = match_index_reg + 1'b1;
                        if (mode_reg == M_KEY && b == CH_BACKSLASH)
                            mode_next = M_KEY_ESC;
                        else
                            mode_next = M_KEY;
                    end
                end
                M_PRE_VALUE:
                begin
                    if (is_blank(b))
                        mode_next = M_PRE_VALUE;
                    else if (b == CH_LBRACE)
                    begin
                        skip_depth_next = depth_t'(1);
                        mode_next       = M_OBJ;
                    end
                    else if (b == CH_LBRACKET)
                    begin
                        skip_depth_next = depth_t'(1);
                        mode_next       = M_ARR;
                    end
                    else if (b == CH_QUOTE)
                        mode_next = M_VSTR;
                    else if (is_stop(b))
                        mode_next = M_SEARCH;
                    else
                        mode_next = M_SCALAR;
                end
                M_VSTR:
                begin
                    if (b == CH_BACKSLASH)
                        mode_next = M_VSTR_ESC;
                    else if (b == CH_QUOTE)
                        mode_next = M_SEARCH;
                end
                M_VSTR_ESC:
                    mode_next = M_VSTR;
                M_OBJ, M_ARR:
                begin
                    // Count only this value's own bracket pair
                    if (b == ((mode_reg == M_OBJ) ? CH_LBRACE : CH_LBRACKET))
                    begin
                        if (skip_depth_reg != '1)
                            skip_depth_next = skip_depth_reg + 1'b1;
                    end
                    else if (b == ((mode_reg == M_OBJ) ? CH_RBRACE : CH_RBRACKET))
                    begin
                        if (skip_depth_reg != '0)
                            skip_depth_next = skip_depth_reg - 1'b1;
                        if (skip_depth_reg <= depth_t'(1))
                            mode_next = M_SEARCH;
                    end
                    else if (b == CH_QUOTE)
                        mode_next = (mode_reg == M_OBJ) ? M_OBJ_STR : M_ARR_STR;
                end
                M_OBJ_STR:
                begin
                    if (b == CH_BACKSLASH)
                        mode_next = M_OBJ_ESC;
                    else if (b == CH_QUOTE)
                        mode_next = M_OBJ;
                end
                M_OBJ_ESC:
                    mode_next = M_OBJ_STR;
                M_ARR_STR:
                begin
                    if (b == CH_BACKSLASH)
                        mode_next = M_ARR_ESC;
                    else if (b == CH_QUOTE)
                        mode_next = M_ARR;
                end
                M_ARR_ESC:
                    mode_next = M_ARR_STR;
                M_SCALAR:
                begin
                    if (is_stop(b))
                        mode_next = M_SEARCH;
                end
                default:
                    mode_next = M_SEARCH;
            endcase
        end

        if (match)
            reported_next = 1'b1;

        // End of document: rearm, else advance the saturating offset
        if (proceed)
        begin
            if (in_last_reg)
            begin
                mode_next         = M_SEARCH;
                byte_count_next   = '0;
                quote_offset_next = '0;
                match_index_next  = '0;
                match_good_next   = 1'b1;
                skip_depth_next   = '0;
                reported_next     = 1'b0;
            end
            else if (byte_count_reg != '1)
            begin
                byte_count_next = byte_count_reg + 1'b1;
            end
        end
    end

    assign out_load = proceed && (match || (in_last_reg && !reported_reg));

    // Control registers and scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_bytes_reg    <= '0;
            key_length_reg   <= '0;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            mode_reg         <= M_SEARCH;
            byte_count_reg   <= '0;
            quote_offset_reg <= '0;
            match_index_reg  <= '0;
            match_good_reg   <= 1'b1;
            skip_depth_reg   <= '0;
            reported_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_KEY_BYTES:  key_bytes_reg  <= cfg_data;
                    CFG_KEY_LENGTH: key_length_reg <= cfg_data[KEY_LEN_W-1:0];
                    default: ;
                endcase
            end

            if (s_tready)
                in_valid_reg <= s_tvalid;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            mode_reg         <= mode_next;
            byte_count_reg   <= byte_count_next;
            quote_offset_reg <= quote_offset_next;
            match_index_reg  <= match_index_next;
            match_good_reg   <= match_good_next;
            skip_depth_reg   <= skip_depth_next;
            reported_reg     <= reported_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (out_load)
        begin
            out_found_reg  <= match;
            out_offset_reg <= match ? KEY_OFFSET_W'(quote_offset_reg) : '0;
        end
    end

    // Outside a skipped value no bracket count is left over
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == M_SEARCH) |-> (skip_depth_reg == '0))
    else $error("skip depth nonzero while searching");

    // The last byte rearms the scan
    assert property (@(posedge clk) disable iff (!rst_n)
        (proceed && in_last_reg) |=> (byte_count_reg == '0 && !reported_reg
                                      && mode_reg == M_SEARCH))
    else $error("scan not rearmed after last byte");

    // A match mid-document marks the document as reported
    assert property (@(posedge clk) disable iff (!rst_n)
        (proceed && match && !in_last_reg) |=> reported_reg)
    else $error("match not recorded");

    // A not-found result carries a zero offset
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_found_reg) |-> (out_offset_reg == '0))
    else $error("not-found result with nonzero offset");

endmodule

`default_nettype wire
